/* sv/bf3_pkg.sv */
// Shared types, widths and constants of the 3x3 box filter.
// Used by the front end, back end and top level; depends on nothing.
`default_nettype none

package bf3_pkg;

   localparam int PIX_W    = 8;
   localparam int POS_W    = 5;
   localparam int SIDE_W   = 6;
   localparam int BUF_W    = 2;
   localparam int LINES    = 3;
   localparam int SUM_W    = 12;
   localparam int RECIP_W  = 14;
   localparam int RECIP_SHIFT = 16;

   localparam logic [SIDE_W-1:0]  SIDE_RESET = 6'd8;
   localparam logic [SIDE_W-1:0]  SIDE_MIN   = 6'd2;
   localparam logic [RECIP_W-1:0] RECIP_SIX  = 14'd10923;
   localparam logic [RECIP_W-1:0] RECIP_NINE = 14'd7282;

   localparam int JOB_DEPTH = 4;
   localparam int RSP_DEPTH = 2;

   typedef struct packed {
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col_first;
      logic [POS_W-1:0] col_last;
      logic [BUF_W-1:0] mid_buf;
      logic             is_drain;
      logic             ends_burst;
   } job_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] col;
      logic             frame_done;
      logic             burst_end;
   } rsp_type;

   typedef struct packed {
      logic job_done;
      logic drain_done;
   } back_status_type;

   localparam int JOB_W = $bits(job_type);
   localparam int RSP_W = $bits(rsp_type);

   function automatic logic [BUF_W-1:0] buf_prev(input logic [BUF_W-1:0] b);
      return (b == 2'd0) ? 2'd2 : b - 2'd1;
   endfunction

   function automatic logic [BUF_W-1:0] buf_next(input logic [BUF_W-1:0] b);
      return (b == 2'd2) ? 2'd0 : b + 2'd1;
   endfunction

endpackage

`default_nettype wire

/* sv/bf3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stands alone; no package needed.
`default_nettype none

module bf3_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 96
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* sv/bf3_fifo.sv */
// Small register queue with push/full and pop/empty sides.
// Stands alone; no package needed.
`default_nettype none

module bf3_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output logic                  empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

/* sv/bf3_front.sv */
// Front end: accepts pixels, writes the line buffers, tracks position and
// issues result jobs. Depends on bf3_pkg.
`default_nettype none

module bf3_front #(
   parameter int MAX_SIDE = 32,
   parameter int ADDR_W   = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_push,
   output logic                               req_full,
   input  wire logic [bf3_pkg::PIX_W-1:0]     req_pixel_in,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [bf3_pkg::SIDE_W-1:0]    csr_image_side,
   output logic      [bf3_pkg::SIDE_W-1:0]    side_eff,
   output logic                               ram_wr_en,
   output logic      [ADDR_W-1:0]             ram_wr_addr,
   output logic      [bf3_pkg::PIX_W-1:0]     ram_wr_data,
   output logic                               job_push,
   output bf3_pkg::job_type                   job_data,
   input  wire bf3_pkg::back_status_type      status
);

   logic [bf3_pkg::SIDE_W-1:0] side_ff, side_in;
   logic [bf3_pkg::POS_W-1:0]  row_ff, row_in;
   logic [bf3_pkg::POS_W-1:0]  col_ff, col_in;
   logic [bf3_pkg::BUF_W-1:0]  newest_ff, newest_in;
   logic [1:0]                 pend_ff, pend_in;
   logic                       drain_out_ff, drain_out_in;
   logic                       last_job_ff, last_job_in;
   logic                       second_ff, second_in;
   bf3_pkg::job_type           hold_ff, hold_in;

   logic [bf3_pkg::SIDE_W-1:0] n_last;
   logic                       at_last_col, at_last_row;
   logic                       accept, make_a, drain, can_take, csr_write;
   bf3_pkg::job_type           job_a, job_b;

   always_comb begin
      if (side_ff < bf3_pkg::SIDE_MIN) begin
         side_eff = bf3_pkg::SIDE_MIN;
      end else if (side_ff > bf3_pkg::SIDE_W'(MAX_SIDE)) begin
         side_eff = bf3_pkg::SIDE_W'(MAX_SIDE);
      end else begin
         side_eff = side_ff;
      end
   end

   assign n_last      = side_eff - 1'b1;
   assign at_last_col = ({1'b0, col_ff} == n_last);
   assign at_last_row = ({1'b0, row_ff} == n_last);
   assign make_a      = (row_ff != '0) && (col_ff != '0);
   assign drain       = at_last_row && at_last_col;
   assign can_take    = (pend_ff == 2'd0) || ((pend_ff == 2'd1) && last_job_ff);
   assign req_full    = second_ff || drain_out_ff || !can_take;
   assign accept      = req_push && !req_full;
   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;

   assign ram_wr_en   = accept;
   assign ram_wr_addr = ADDR_W'(int'(newest_ff) * MAX_SIDE + int'(col_ff));
   assign ram_wr_data = req_pixel_in;

   always_comb begin
      job_a.row        = row_ff - 1'b1;
      job_a.col_first  = col_ff - 1'b1;
      job_a.col_last   = at_last_col ? n_last[bf3_pkg::POS_W-1:0] : col_ff - 1'b1;
      job_a.mid_buf    = bf3_pkg::buf_prev(newest_ff);
      job_a.is_drain   = 1'b0;
      job_a.ends_burst = !drain;

      job_b.row        = n_last[bf3_pkg::POS_W-1:0];
      job_b.col_first  = '0;
      job_b.col_last   = n_last[bf3_pkg::POS_W-1:0];
      job_b.mid_buf    = newest_ff;
      job_b.is_drain   = 1'b1;
      job_b.ends_burst = 1'b1;
   end

   assign job_push = (accept && make_a) || second_ff;
   assign job_data = second_ff ? hold_ff : job_a;

   always_comb begin
      side_in      = side_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      newest_in    = newest_ff;
      last_job_in  = last_job_ff;
      hold_in      = hold_ff;
      second_in    = 1'b0;
      drain_out_in = drain_out_ff;
      pend_in      = pend_ff + {1'b0, job_push} - {1'b0, status.job_done};

      if (status.drain_done) begin
         drain_out_in = 1'b0;
      end

      if (accept) begin
         last_job_in = make_a;
         if (drain) begin
            hold_in      = job_b;
            second_in    = 1'b1;
            drain_out_in = 1'b1;
         end
         if (at_last_col) begin
            col_in    = '0;
            newest_in = bf3_pkg::buf_next(newest_ff);
            row_in    = at_last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end

      if (csr_write) begin
         side_in   = csr_image_side;
         row_in    = '0;
         col_in    = '0;
         newest_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff      <= bf3_pkg::SIDE_RESET;
         row_ff       <= '0;
         col_ff       <= '0;
         newest_ff    <= '0;
         pend_ff      <= '0;
         drain_out_ff <= 1'b0;
         last_job_ff  <= 1'b0;
         second_ff    <= 1'b0;
      end else begin
         side_ff      <= side_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         newest_ff    <= newest_in;
         pend_ff      <= pend_in;
         drain_out_ff <= drain_out_in;
         last_job_ff  <= last_job_in;
         second_ff    <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

endmodule

`default_nettype wire

/* sv/bf3_back.sv */
// Back end: runs each job over its columns, reads the in-image taps of the nine
// from the line buffers, sums them and divides by 4, 6 or 9. Depends on bf3_pkg.
`default_nettype none

module bf3_back #(
   parameter int MAX_SIDE = 32,
   parameter int ADDR_W   = 7
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [bf3_pkg::SIDE_W-1:0]    side_eff,
   input  wire logic                          job_empty,
   output logic                               job_pop,
   input  wire bf3_pkg::job_type              job_data,
   output logic                               ram_rd_en,
   output logic      [ADDR_W-1:0]             ram_rd_addr,
   input  wire logic [bf3_pkg::PIX_W-1:0]     ram_rd_data,
   input  wire logic                          rsp_full,
   output logic                               rsp_push,
   output bf3_pkg::rsp_type                   rsp_data,
   output bf3_pkg::back_status_type           status
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TAPS = 2'd1;
   localparam logic [1:0] ST_LAST = 2'd2;
   localparam logic [1:0] ST_DIV  = 2'd3;

   localparam int PROD_W = bf3_pkg::SUM_W + bf3_pkg::RECIP_W;

   logic [1:0]                 state_ff, state_in;
   bf3_pkg::job_type           job_ff, job_in;
   logic [bf3_pkg::POS_W-1:0]  col_ff, col_in;
   logic [1:0]                 tr_ff, tr_in;
   logic [1:0]                 tc_ff, tc_in;
   logic [bf3_pkg::SUM_W-1:0]  acc_ff, acc_in;
   logic                       rd_pend_ff;

   logic [bf3_pkg::SIDE_W-1:0]  n_last;
   logic                        up_ok, dn_ok, lf_ok, rt_ok;
   logic                        row_ok, col_ok, last_col, full_rows, full_cols;
   logic [bf3_pkg::BUF_W-1:0]   tap_buf;
   logic [bf3_pkg::POS_W-1:0]   tap_col;
   logic [bf3_pkg::SUM_W-1:0]   acc_sum;
   logic [bf3_pkg::RECIP_W-1:0] recip;
   logic [PROD_W-1:0]           prod;
   logic [bf3_pkg::PIX_W-1:0]   mean;

   assign n_last = side_eff - 1'b1;
   assign up_ok  = (job_ff.row != '0);
   assign dn_ok  = ({1'b0, job_ff.row} != n_last);
   assign lf_ok  = (col_ff != '0);
   assign rt_ok  = ({1'b0, col_ff} != n_last);

   always_comb begin
      case (tr_ff)
         2'd0: begin
            row_ok  = up_ok;
            tap_buf = bf3_pkg::buf_prev(job_ff.mid_buf);
         end
         2'd1: begin
            row_ok  = 1'b1;
            tap_buf = job_ff.mid_buf;
         end
         default: begin
            row_ok  = dn_ok;
            tap_buf = bf3_pkg::buf_next(job_ff.mid_buf);
         end
      endcase
      case (tc_ff)
         2'd0: begin
            col_ok  = lf_ok;
            tap_col = col_ff - 1'b1;
         end
         2'd1: begin
            col_ok  = 1'b1;
            tap_col = col_ff;
         end
         default: begin
            col_ok  = rt_ok;
            tap_col = col_ff + 1'b1;
         end
      endcase
   end

   assign ram_rd_en   = (state_ff == ST_TAPS) && row_ok && col_ok;
   assign ram_rd_addr = ADDR_W'(int'(tap_buf) * MAX_SIDE + int'(tap_col));

   assign acc_sum = acc_ff + (rd_pend_ff ? bf3_pkg::SUM_W'(ram_rd_data) : '0);

   assign full_rows = up_ok && dn_ok;
   assign full_cols = lf_ok && rt_ok;
   assign recip     = (full_rows && full_cols) ? bf3_pkg::RECIP_NINE : bf3_pkg::RECIP_SIX;
   assign prod      = PROD_W'(acc_ff) * PROD_W'(recip);

   always_comb begin
      if (full_rows || full_cols) begin
         mean = prod[bf3_pkg::RECIP_SHIFT +: bf3_pkg::PIX_W];
      end else begin
         mean = acc_ff[2 +: bf3_pkg::PIX_W];
      end
   end

   assign last_col = (col_ff == job_ff.col_last);
   assign rsp_push = (state_ff == ST_DIV) && !rsp_full;
   assign job_pop  = (state_ff == ST_IDLE) && !job_empty;

   always_comb begin
      rsp_data.pixel      = mean;
      rsp_data.row        = job_ff.row;
      rsp_data.col        = col_ff;
      rsp_data.frame_done = job_ff.is_drain && last_col;
      rsp_data.burst_end  = job_ff.ends_burst && last_col;
      status.job_done     = rsp_push && last_col;
      status.drain_done   = rsp_push && last_col && job_ff.is_drain;
   end

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      col_in   = col_ff;
      tr_in    = tr_ff;
      tc_in    = tc_ff;
      acc_in   = acc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_pop) begin
               job_in   = job_data;
               col_in   = job_data.col_first;
               tr_in    = '0;
               tc_in    = '0;
               acc_in   = '0;
               state_in = ST_TAPS;
            end
         end
         ST_TAPS: begin
            acc_in = acc_sum;
            if (tc_ff == 2'd2) begin
               tc_in = '0;
               if (tr_ff == 2'd2) begin
                  state_in = ST_LAST;
               end else begin
                  tr_in = tr_ff + 1'b1;
               end
            end else begin
               tc_in = tc_ff + 1'b1;
            end
         end
         ST_LAST: begin
            acc_in   = acc_sum;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (rsp_push) begin
               if (last_col) begin
                  state_in = ST_IDLE;
               end else begin
                  col_in   = col_ff + 1'b1;
                  tr_in    = '0;
                  tc_in    = '0;
                  acc_in   = '0;
                  state_in = ST_TAPS;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rd_pend_ff <= 1'b0;
         tr_ff      <= '0;
         tc_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= ram_rd_en;
         tr_ff      <= tr_in;
         tc_ff      <= tc_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      col_ff <= col_in;
      acc_ff <= acc_in;
   end

endmodule

`default_nettype wire

/* sv/box_filter_3x3_edge_average_core.sv */
// Top level of the 3x3 box filter: front end, line buffer RAM, job queue,
// back end and result queue. Depends on bf3_pkg and all bf3_ modules.
//
// Pixels of a square image enter in raster order on the req_ queue side
// (push/full). Each result gives the floor mean of the in-image 3x3
// neighbours of one position with its row and column, in raster order one
// row behind the input; the last pixel of a frame also emits the final row
// as a burst. burst_end marks the last result caused by one pixel and
// frame_done the last result of the frame. Results wait on the rsp_ queue
// side (empty/pop). csr_image_side sets the side (2 to MAX_SIDE) and
// restarts the frame; write it only while the block is idle.
// In the back end each result takes nine tap steps, which read the
// in-image taps through the single line-buffer read port, then one
// accumulate and one divide step; each job also takes an idle step to
// leave the job queue. The front end accepts the next pixel while the
// back end works on the previous one's job and then waits for that job
// to finish. Reset sets the side to 8 and clears position and queues;
// line buffer contents are left as they are. A stalled receiver fills
// the result queue, holds the back end and then raises req_full.
`default_nettype none

module box_filter_3x3_edge_average_core #(
   parameter int MAX_SIDE = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_push,
   output logic                             req_full,
   input  wire logic [bf3_pkg::PIX_W-1:0]   req_pixel_in,
   output logic                             rsp_empty,
   input  wire logic                        rsp_pop,
   output logic      [bf3_pkg::PIX_W-1:0]   rsp_smoothed_pixel,
   output logic      [bf3_pkg::POS_W-1:0]   rsp_out_row,
   output logic      [bf3_pkg::POS_W-1:0]   rsp_out_col,
   output logic                             rsp_frame_done,
   output logic                             rsp_burst_end,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [bf3_pkg::SIDE_W-1:0]  csr_image_side
);

   localparam int DEPTH  = bf3_pkg::LINES * MAX_SIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   logic [bf3_pkg::SIDE_W-1:0] side_eff;
   logic                       ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]          ram_wr_addr, ram_rd_addr;
   logic [bf3_pkg::PIX_W-1:0]  ram_wr_data, ram_rd_data;

   logic                       job_push, job_full, job_pop, job_empty;
   bf3_pkg::job_type           job_in, job_out;
   logic [bf3_pkg::JOB_W-1:0]  job_out_bits;

   logic                       rsp_push, rsp_full;
   bf3_pkg::rsp_type           rsp_in, rsp_head;
   logic [bf3_pkg::RSP_W-1:0]  rsp_head_bits;

   bf3_pkg::back_status_type   status;

   bf3_front #(
      .MAX_SIDE (MAX_SIDE),
      .ADDR_W   (ADDR_W)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_pixel_in   (req_pixel_in),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_image_side (csr_image_side),
      .side_eff       (side_eff),
      .ram_wr_en      (ram_wr_en),
      .ram_wr_addr    (ram_wr_addr),
      .ram_wr_data    (ram_wr_data),
      .job_push       (job_push),
      .job_data       (job_in),
      .status         (status)
   );

   bf3_ram #(
      .WIDTH (bf3_pkg::PIX_W),
      .DEPTH (DEPTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bf3_fifo #(
      .WIDTH (bf3_pkg::JOB_W),
      .DEPTH (bf3_pkg::JOB_DEPTH)
   ) u_job_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .pop_data  (job_out_bits),
      .empty     (job_empty)
   );

   assign job_out = bf3_pkg::job_type'(job_out_bits);

   bf3_back #(
      .MAX_SIDE (MAX_SIDE),
      .ADDR_W   (ADDR_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .side_eff    (side_eff),
      .job_empty   (job_empty),
      .job_pop     (job_pop),
      .job_data    (job_out),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_in),
      .status      (status)
   );

   bf3_fifo #(
      .WIDTH (bf3_pkg::RSP_W),
      .DEPTH (bf3_pkg::RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_head_bits),
      .empty     (rsp_empty)
   );

   assign rsp_head           = bf3_pkg::rsp_type'(rsp_head_bits);
   assign rsp_smoothed_pixel = rsp_head.pixel;
   assign rsp_out_row        = rsp_head.row;
   assign rsp_out_col        = rsp_head.col;
   assign rsp_frame_done     = rsp_head.frame_done;
   assign rsp_burst_end      = rsp_head.burst_end;

   a_job_room: assert property (@(posedge clock) disable iff (reset)
      job_push |-> !job_full)
      else $error("job queue pushed while full");

   a_rsp_room: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result queue pushed while full");

   a_frame_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_in.frame_done) |-> rsp_in.burst_end)
      else $error("frame end result without burst end");

   a_drain_done: assert property (@(posedge clock) disable iff (reset)
      status.drain_done |-> status.job_done)
      else $error("drain job finished outside a job completion");

endmodule

`default_nettype wire
